@@ src/mms_pkg.sv @@
// ============================================================================
// mms_pkg - shared constants, types and helpers of the moving sum block
// Sizes of the channel store, the window, the totals and the divider.
// ============================================================================
package mms_pkg;

   localparam int CHANNELS    = 16;
   localparam int MAX_WINDOW  = 1024;
   localparam int SAMPLE_BITS = 16;

   localparam int CH_IN_BITS  = 4;
   localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_BITS    = $clog2(MAX_WINDOW);
   localparam int SIZE_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int X_BITS      = 2 * SAMPLE_BITS;
   localparam int DELAY_BITS  = 32;
   localparam int TOTAL_BITS  = 42;
   localparam int ADDR_BITS   = CH_BITS + POS_BITS;
   localparam int RAM_DEPTH   = CHANNELS * MAX_WINDOW;

   localparam int WS_BITS       = 11;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVERAGE_MODE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SQUARE_MODE  = 2'd2;

   localparam int WS_RESET = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // divider: DIV_STEPS quotient bits per cycle
   localparam int DIV_STEPS    = 4;
   localparam int DIV_ITER     = (TOTAL_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_BITS     = DIV_ITER * DIV_STEPS;
   localparam int DIV_CNT_BITS = $clog2(DIV_ITER + 1);

   typedef struct packed {
      logic [CH_IN_BITS-1:0]    ch;
      logic                     ok;
      logic signed [X_BITS-1:0] x;
   } item_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] size;
      logic                 avg;
      logic                 sq;
   } cfg_type;

   // zero counts as one, oversize clamps to the deepest window
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [WS_BITS-1:0] ws);
      logic [SIZE_BITS-1:0] s;
      if (ws == '0) begin
         s = SIZE_BITS'(1);
      end else if (32'(ws) > MAX_WINDOW) begin
         s = SIZE_BITS'(MAX_WINDOW);
      end else begin
         s = SIZE_BITS'(ws);
      end
      return s;
   endfunction

endpackage

@@ src/multichannel_moving_sum_top.sv @@
// ============================================================================
// multichannel_moving_sum_top - per-channel moving window sum or average
// Sample words enter on req_*, one result word per sample leaves on rsp_*.
// csr_* writes window_size (index 0), average_mode (1) and square_mode (2);
// write it only while the block is idle. csr_ready is always high.
// A sample reaches rsp_* through the input register, the two-entry queue and
// the delay line read-modify-write, and with averaging also the divider.
// The channel engine takes one sample at a time: the delay RAM read followed
// by its write, and with averaging then the divider, which retires 4 quotient
// bits a cycle over 11 iterations.
// Reset clears totals, window positions and configuration at once. The delay
// line is not swept: a per-channel fill mark makes unwritten entries read as
// zero, so samples are accepted in the first cycle after reset.
// When the receiver stalls, the result register holds its word, and the
// input register and queue keep taking up to three more samples.
// ============================================================================
module multichannel_moving_sum_top
   import mms_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CH_IN_BITS-1:0]         req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CH_IN_BITS-1:0]         rsp_out_channel,
   output logic signed [TOTAL_BITS-1:0]  rsp_window_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   logic [WS_BITS-1:0] ws_ff, ws_in;
   logic               avg_ff, avg_in;
   logic               sq_ff, sq_in;
   cfg_type            cfg;
   logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   item_type           q_in_item, q_out_item;

   assign csr_ready = 1'b1;

   always_comb begin
      ws_in  = ws_ff;
      avg_in = avg_ff;
      sq_in  = sq_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:  ws_in  = WS_BITS'(csr_data);
            CSR_AVERAGE_MODE: avg_in = csr_data[0];
            CSR_SQUARE_MODE:  sq_in  = csr_data[0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff  <= WS_BITS'(WS_RESET);
         avg_ff <= 1'b0;
         sq_ff  <= 1'b0;
      end else begin
         ws_ff  <= ws_in;
         avg_ff <= avg_in;
         sq_ff  <= sq_in;
      end
   end

   always_comb begin
      cfg.size = eff_size(ws_ff);
      cfg.avg  = avg_ff;
      cfg.sq   = sq_ff;
   end

   mms_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .square_mode (cfg.sq),
      .push_valid  (q_in_valid),
      .push_ready  (q_in_ready),
      .push_item   (q_in_item)
   );

   mms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_item   (q_in_item),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_item  (q_out_item)
   );

   mms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .pop_valid        (q_out_valid),
      .pop_ready        (q_out_ready),
      .pop_item         (q_out_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_window_value (rsp_window_value)
   );

endmodule

@@ src/mms_ram.sv @@
// ============================================================================
// mms_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module mms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/mms_front.sv @@
// ============================================================================
// mms_front - input stage of the moving sum block
// Takes sample words, checks the channel and squares the sample on request.
// ============================================================================
module mms_front
   import mms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CH_IN_BITS-1:0]  req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                   square_mode,
   output logic                   push_valid,
   input  logic                   push_ready,
   output item_type               push_item
);

   logic                          fr_valid_ff, fr_valid_in;
   logic [CH_IN_BITS-1:0]         fr_ch_ff, fr_ch_in;
   logic signed [SAMPLE_BITS-1:0] fr_sample_ff, fr_sample_in;
   logic signed [X_BITS-1:0]      square;

   assign req_ready  = !fr_valid_ff || push_ready;
   assign push_valid = fr_valid_ff;
   assign square     = fr_sample_ff * fr_sample_ff;

   always_comb begin
      push_item.ch = fr_ch_ff;
      push_item.ok = 32'(fr_ch_ff) < CHANNELS;
      push_item.x  = square_mode ? square : X_BITS'(fr_sample_ff);
   end

   always_comb begin
      fr_valid_in  = fr_valid_ff;
      fr_ch_in     = fr_ch_ff;
      fr_sample_in = fr_sample_ff;
      if (req_ready) begin
         fr_valid_in = req_valid;
      end
      if (req_valid && req_ready) begin
         fr_ch_in     = req_channel;
         fr_sample_in = req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_ch_ff     <= fr_ch_in;
      fr_sample_ff <= fr_sample_in;
   end

endmodule

@@ src/mms_queue.sv @@
// ============================================================================
// mms_queue - short queue between the input stage and the channel engine
// Lets either side stall on its own.
// ============================================================================
module mms_queue
   import mms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ src/mms_div.sv @@
// ============================================================================
// mms_div - signed total divided by the window size
// Restoring division, DIV_STEPS quotient bits per cycle, truncates toward zero.
// ============================================================================
module mms_div
   import mms_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [TOTAL_BITS-1:0] dividend,
   input  logic [SIZE_BITS-1:0]         divisor,
   output logic                         done,
   output logic signed [TOTAL_BITS-1:0] quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [SIZE_BITS-1:0]    rem_ff, rem_in;
   logic [SIZE_BITS-1:0]    dvs_ff, dvs_in;

   always_comb begin
      logic [SIZE_BITS:0]    t;
      logic [TOTAL_BITS-1:0] mag;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      t       = '0;
      mag     = '0;
      if (start) begin
         mag     = dividend[TOTAL_BITS-1] ? $unsigned(-dividend) : $unsigned(dividend);
         neg_in  = dividend[TOTAL_BITS-1];
         quo_in  = DIV_BITS'(mag);
         rem_in  = '0;
         cnt_in  = '0;
         dvs_in  = divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            t      = {rem_in, quo_in[DIV_BITS-1]};
            quo_in = {quo_in[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, dvs_ff}) begin
               rem_in    = SIZE_BITS'(t - {1'b0, dvs_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = SIZE_BITS'(t);
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff[TOTAL_BITS-1:0])
                            : $signed(quo_ff[TOTAL_BITS-1:0]);

endmodule

@@ src/mms_back.sv @@
// ============================================================================
// mms_back - channel engine of the moving sum block
// Read-modify-write of the delay line, total update, optional averaging.
// ============================================================================
module mms_back
   import mms_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  item_type                     pop_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [CH_IN_BITS-1:0]        rsp_out_channel,
   output logic signed [TOTAL_BITS-1:0] rsp_window_value
);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV} state_type;

   state_type                    state_ff, state_in;
   logic [CH_IN_BITS-1:0]        cur_ch_ff, cur_ch_in;
   logic signed [X_BITS-1:0]     cur_x_ff, cur_x_in;
   logic [POS_BITS-1:0]          cur_pos_ff, cur_pos_in;
   logic [SIZE_BITS-1:0]         cur_hw_ff, cur_hw_in;
   logic signed [TOTAL_BITS-1:0] cur_run_ff, cur_run_in;
   logic signed [TOTAL_BITS-1:0] cur_safe_ff, cur_safe_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CH_IN_BITS-1:0]        rsp_ch_ff, rsp_ch_in;
   logic signed [TOTAL_BITS-1:0] rsp_val_ff, rsp_val_in;

   // per-channel state; hw_ff counts delay entries written since reset
   logic [POS_BITS-1:0]          pos_ff [CHANNELS];
   logic [SIZE_BITS-1:0]         hw_ff [CHANNELS];
   logic signed [TOTAL_BITS-1:0] run_ff [CHANNELS];
   logic signed [TOTAL_BITS-1:0] safe_ff [CHANNELS];

   logic                         tot_we;
   logic [POS_BITS-1:0]          pos_in;
   logic [SIZE_BITS-1:0]         hw_in;
   logic signed [TOTAL_BITS-1:0] run_in, safe_in;

   logic                         pop;
   logic [CH_BITS-1:0]           pop_idx, cur_idx;
   logic [DELAY_BITS-1:0]        ram_rdata;
   logic signed [TOTAL_BITS-1:0] x_ext, old_ext, new_run, new_safe;
   logic [SIZE_BITS-1:0]         pos_next;
   logic                         wrap;
   logic                         div_start, div_done;
   logic signed [TOTAL_BITS-1:0] div_q;

   assign pop_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign pop       = pop_valid && pop_ready;
   assign pop_idx   = CH_BITS'(pop_item.ch);
   assign cur_idx   = CH_BITS'(cur_ch_ff);

   mms_ram #(
      .WIDTH (DELAY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_delay (
      .clock (clock),
      .we    (state_ff == ST_READ),
      .waddr ({cur_idx, cur_pos_ff}),
      .wdata (DELAY_BITS'(cur_x_ff)),
      .raddr ({pop_idx, pos_ff[pop_idx]}),
      .rdata (ram_rdata)
   );

   // entries past the fill mark were never written and read as zero
   assign x_ext    = TOTAL_BITS'(cur_x_ff);
   assign old_ext  = (SIZE_BITS'(cur_pos_ff) < cur_hw_ff) ? TOTAL_BITS'($signed(ram_rdata)) : '0;
   assign new_safe = cur_safe_ff + x_ext;
   assign new_run  = cur_run_ff + (x_ext - old_ext);
   assign pos_next = SIZE_BITS'(cur_pos_ff) + 1'b1;
   assign wrap     = pos_next >= cfg.size;

   assign tot_we  = state_ff == ST_READ;
   assign pos_in  = wrap ? '0 : POS_BITS'(pos_next);
   assign run_in  = wrap ? new_safe : new_run;
   assign safe_in = wrap ? '0 : new_safe;
   assign hw_in   = (SIZE_BITS'(cur_pos_ff) == cur_hw_ff) ? pos_next : cur_hw_ff;

   assign div_start = (state_ff == ST_READ) && cfg.avg;

   mms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_run),
      .divisor  (cfg.size),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      cur_ch_in    = cur_ch_ff;
      cur_x_in     = cur_x_ff;
      cur_pos_in   = cur_pos_ff;
      cur_hw_in    = cur_hw_ff;
      cur_run_in   = cur_run_ff;
      cur_safe_in  = cur_safe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_val_in   = rsp_val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (pop_item.ok) begin
                  cur_ch_in   = pop_item.ch;
                  cur_x_in    = pop_item.x;
                  cur_pos_in  = pos_ff[pop_idx];
                  cur_hw_in   = hw_ff[pop_idx];
                  cur_run_in  = run_ff[pop_idx];
                  cur_safe_in = safe_ff[pop_idx];
                  state_in    = ST_READ;
               end else begin
                  // unknown channel: pass it through with a zero value
                  rsp_valid_in = 1'b1;
                  rsp_ch_in    = pop_item.ch;
                  rsp_val_in   = '0;
               end
            end
         end
         ST_READ: begin
            if (cfg.avg) begin
               state_in = ST_DIV;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = cur_ch_ff;
               rsp_val_in   = new_run;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = cur_ch_ff;
               rsp_val_in   = div_q;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i]  <= '0;
            hw_ff[i]   <= '0;
            run_ff[i]  <= '0;
            safe_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tot_we) begin
            pos_ff[cur_idx]  <= pos_in;
            hw_ff[cur_idx]   <= hw_in;
            run_ff[cur_idx]  <= run_in;
            safe_ff[cur_idx] <= safe_in;
         end
      end
      cur_ch_ff   <= cur_ch_in;
      cur_x_ff    <= cur_x_in;
      cur_pos_ff  <= cur_pos_in;
      cur_hw_ff   <= cur_hw_in;
      cur_run_ff  <= cur_run_in;
      cur_safe_ff <= cur_safe_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_val_ff  <= rsp_val_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_ch_ff;
   assign rsp_window_value = rsp_val_ff;

   a_read_follows_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_IDLE))
      else $error("delay read stage entered from a state other than idle");

   a_pos_within_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (SIZE_BITS'(cur_pos_ff) <= cur_hw_ff))
      else $error("window position ran past the delay line fill mark");

   a_pop_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid_ff || rsp_ready))
      else $error("word taken from queue while a result is still held");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_val_ff)))
      else $error("held result changed before it was taken");

endmodule
